### sv/tsgt_pkg.sv
// Shared package for the time segment gap tracker.
// Holds sizes, status and opcode codes, the controller/datapath structs and the ring slot helper.
// No dependencies.
`default_nettype none

package tsgt_pkg;

  // Ring size and derived widths
  localparam int SEGMENT_DEPTH = 16;
  localparam int IDX_W         = $clog2(SEGMENT_DEPTH);
  localparam int CNT_W         = $clog2(SEGMENT_DEPTH + 1);
  localparam int TIME_W        = 64;
  localparam int STATUS_W      = 3;
  localparam int SEG_W         = 2 * TIME_W + 1;

  // Opcodes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BEYOND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ORDER  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SHRINK = 3'd5;

  // Controller to datapath commands
  typedef struct packed {
    logic                load;
    logic                rd_last;
    logic                wr_merge;
    logic                wr_replace;
    logic                wr_add;
    logic                walk_start;
    logic                walk_step;
    logic                commit_flush;
    logic                finish;
    logic [STATUS_W-1:0] code;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_query;
    logic order_bad;
    logic empty;
    logic full;
    logic merge_hit;
    logic shrink;
    logic last_empty;
    logic beyond;
    logic walk_done;
  } dp_stat_t;

  // Ring slot of position pos counted from the oldest slot
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] oldest,
                                               input logic [CNT_W-1:0] pos);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(oldest) + (CNT_W + 1)'(pos);
    if (sum >= (CNT_W + 1)'(SEGMENT_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(SEGMENT_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/tsgt_if.sv
// Valid/ready channel interfaces for the request and response items.
// Depends on tsgt_pkg for field widths.
`default_nettype none

interface tsgt_req_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [tsgt_pkg::TIME_W-1:0]   start_time;
  logic [tsgt_pkg::TIME_W-1:0]   stop_time;
  logic                          gap_mark;

  modport source (output valid, opcode, start_time, stop_time, gap_mark, input ready);
  modport sink   (input valid, opcode, start_time, stop_time, gap_mark, output ready);
endinterface

interface tsgt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          window_is_gap;
  logic [tsgt_pkg::TIME_W-1:0]   gap_duration;
  logic [tsgt_pkg::STATUS_W-1:0] status;

  modport source (output valid, window_is_gap, gap_duration, status, input ready);
  modport sink   (input valid, window_is_gap, gap_duration, status, output ready);
endinterface

`default_nettype wire

### sv/tsgt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tsgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/tsgt_datapath.sv
// Datapath: segment ring storage, ring pointers, walk pipeline and result registers.
// Depends on tsgt_pkg and tsgt_ram.
`default_nettype none

module tsgt_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_opcode,
  input  wire logic [tsgt_pkg::TIME_W-1:0]   req_start,
  input  wire logic [tsgt_pkg::TIME_W-1:0]   req_stop,
  input  wire logic                          req_gap,
  input  wire tsgt_pkg::dp_cmd_t             cmd,
  output tsgt_pkg::dp_stat_t                 stat,
  output logic                               res_gap,
  output logic      [tsgt_pkg::TIME_W-1:0]   res_dur,
  output logic      [tsgt_pkg::STATUS_W-1:0] res_status
);
  import tsgt_pkg::*;

  // Latched item
  logic              op;
  logic [TIME_W-1:0] s_t;
  logic [TIME_W-1:0] e_t;
  logic              g;
  logic [TIME_W-1:0] half;

  // Ring pointers
  logic [IDX_W-1:0] oldest;
  logic [CNT_W-1:0] count;

  // Walk pipeline
  logic [CNT_W-1:0]  rd_pos;
  logic [CNT_W-1:0]  ev_pos;
  logic              ev_valid;
  logic              broken;
  logic [TIME_W-1:0] part;
  logic              part_valid;
  logic [TIME_W-1:0] sum;
  logic [CNT_W-1:0]  flush;

  // RAM side
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [SEG_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [SEG_W-1:0]  ram_rdata;
  logic [TIME_W-1:0] rd_start;
  logic [TIME_W-1:0] rd_stop;
  logic              rd_gap;

  logic [IDX_W-1:0]  last_slot;
  logic [IDX_W-1:0]  new_slot;
  logic [IDX_W-1:0]  walk_slot;

  logic              ev_live;
  logic              hit_break;
  logic              hit_flush;
  logic [TIME_W-1:0] lo;
  logic [TIME_W-1:0] hi;
  logic [TIME_W-1:0] part_next;
  logic [TIME_W:0]   acc;
  logic [TIME_W-1:0] sum_sat;

  assign rd_start = ram_rdata[SEG_W-1 -: TIME_W];
  assign rd_stop  = ram_rdata[TIME_W:1];
  assign rd_gap   = ram_rdata[0];

  assign last_slot = slot_of(oldest, count - CNT_W'(1));
  assign new_slot  = slot_of(oldest, count);
  assign walk_slot = slot_of(oldest, rd_pos);

  // Storage port muxing
  assign ram_we    = cmd.wr_merge | cmd.wr_replace | cmd.wr_add;
  assign ram_waddr = cmd.wr_add ? new_slot : last_slot;
  assign ram_wdata = cmd.wr_merge ? {rd_start, e_t, rd_gap} : {s_t, e_t, g};
  assign ram_re    = cmd.rd_last | cmd.walk_step;
  assign ram_raddr = cmd.rd_last ? last_slot : walk_slot;

  tsgt_ram #(
    .WIDTH (SEG_W),
    .DEPTH (SEGMENT_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Overlap of the segment under evaluation with the window
  assign ev_live   = ev_valid && !broken;
  assign hit_break = rd_start >= e_t;
  assign hit_flush = rd_stop <= s_t;
  assign lo        = (rd_start > s_t) ? rd_start : s_t;
  assign hi        = (rd_stop < e_t) ? rd_stop : e_t;
  assign part_next = (hi >= lo) ? hi - lo : '0;

  // Saturating accumulate
  assign acc     = {1'b0, sum} + {1'b0, part};
  assign sum_sat = acc[TIME_W] ? '1 : acc[TIME_W-1:0];

  // Status toward the controller
  always_comb begin
    stat.is_query   = (op == OP_QUERY);
    stat.order_bad  = s_t > e_t;
    stat.empty      = (count == '0);
    stat.full       = (count == CNT_W'(SEGMENT_DEPTH));
    stat.merge_hit  = (rd_gap == g) && (rd_stop >= s_t);
    stat.shrink     = e_t < rd_stop;
    stat.last_empty = (rd_stop == rd_start);
    stat.beyond     = rd_stop < e_t;
    stat.walk_done  = !part_valid && (broken || ((rd_pos >= count) && !ev_valid));
  end

  // Item latch and half window
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= req_opcode;
      s_t <= req_start;
      e_t <= req_stop;
      g   <= req_gap;
    end
    half <= (e_t - s_t) >> 1;
  end

  // Ring pointers and walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest     <= '0;
      count      <= '0;
      ev_valid   <= 1'b0;
      broken     <= 1'b0;
      part_valid <= 1'b0;
    end else begin
      if (cmd.wr_add) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.walk_start) begin
        rd_pos     <= '0;
        ev_valid   <= 1'b0;
        broken     <= 1'b0;
        part_valid <= 1'b0;
        sum        <= '0;
        flush      <= '0;
      end
      if (cmd.walk_step) begin
        if (rd_pos < count) begin
          rd_pos <= rd_pos + CNT_W'(1);
        end
        ev_valid <= rd_pos < count;
        ev_pos   <= rd_pos;
        if (ev_live) begin
          if (hit_break) begin
            broken <= 1'b1;
          end else if (hit_flush) begin
            flush <= ev_pos + CNT_W'(1);
          end
        end
        part_valid <= ev_live && !hit_break && !hit_flush && rd_gap;
        part       <= part_next;
        if (part_valid) begin
          sum <= sum_sat;
        end
      end
      if (cmd.commit_flush && (flush != '0)) begin
        oldest <= slot_of(oldest, flush);
        count  <= count - flush;
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_status <= cmd.code;
      if ((cmd.code == ST_OK) && (op == OP_QUERY)) begin
        res_dur <= sum;
        res_gap <= sum >= half;
      end else begin
        res_dur <= '0;
        res_gap <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### sv/tsgt_ctrl.sv
// Controller: sequences append and query items and drives the datapath commands.
// Depends on tsgt_pkg.
`default_nettype none

module tsgt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  input  wire tsgt_pkg::dp_stat_t stat,
  output tsgt_pkg::dp_cmd_t       cmd
);
  import tsgt_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    LAST_EV,
    WALK,
    FINISH,
    RESPOND
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = ST_OK;
    case (state)
      IDLE: begin
        if (req_valid && req_ready) begin
          cmd.load   = 1'b1;
          state_next = CHECK;
        end
      end
      CHECK: begin
        if (!stat.is_query && stat.order_bad) begin
          cmd.finish = 1'b1;
          cmd.code   = ST_ORDER;
          state_next = RESPOND;
        end else if (stat.empty) begin
          // empty ring: append goes straight in, query has nothing to look at
          cmd.finish = 1'b1;
          if (stat.is_query) begin
            cmd.code = ST_EMPTY;
          end else begin
            cmd.wr_add = 1'b1;
          end
          state_next = RESPOND;
        end else begin
          cmd.rd_last = 1'b1;
          state_next  = LAST_EV;
        end
      end
      LAST_EV: begin
        if (!stat.is_query) begin
          cmd.finish = 1'b1;
          state_next = RESPOND;
          if (stat.merge_hit) begin
            if (stat.shrink) begin
              cmd.code = ST_SHRINK;
            end else begin
              cmd.wr_merge = 1'b1;
            end
          end else if (stat.last_empty) begin
            cmd.wr_replace = 1'b1;
          end else if (stat.full) begin
            cmd.code = ST_FULL;
          end else begin
            cmd.wr_add = 1'b1;
          end
        end else if (stat.beyond) begin
          cmd.finish = 1'b1;
          cmd.code   = ST_BEYOND;
          state_next = RESPOND;
        end else if (stat.order_bad) begin
          cmd.finish = 1'b1;
          cmd.code   = ST_ORDER;
          state_next = RESPOND;
        end else begin
          cmd.walk_start = 1'b1;
          state_next     = WALK;
        end
      end
      WALK: begin
        if (stat.walk_done) begin
          state_next = FINISH;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      FINISH: begin
        cmd.commit_flush = 1'b1;
        cmd.finish       = 1'b1;
        state_next       = RESPOND;
      end
      RESPOND: begin
        if (rsp_ready) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // State and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      req_ready <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      req_ready <= (state_next == IDLE);
      rsp_valid <= (state_next == RESPOND);
    end
  end

endmodule

`default_nettype wire

### sv/time_segment_gap_tracker.sv
// Top level of the time segment gap tracker: controller, datapath and checks.
// Depends on tsgt_pkg, tsgt_if, tsgt_ctrl and tsgt_datapath.
//
// Keeps a ring of up to SEGMENT_DEPTH time segments (start, exclusive stop, gap mark) and
// answers one result item for every request item, one item at a time. An append is
// checked while the newest segment is read from the ring RAM, then merged, replaced or
// added, or refused as full or shrinking. An append to an empty ring or with start after
// stop, and a query on an empty ring, answer straight from that check. A query is rejected
// against the newest stop or for start after stop once the newest segment has been read.
// A query that walks the ring reads one segment per cycle through the single RAM read
// port, then drains the overlap and sum pipeline (RAM read data, partial overlap, running
// sum), then drops leading segments that ended before the window and registers the
// result. The walk stops early at the first segment that starts at or after the window
// stop. The next item is accepted no earlier than the cycle after the result item has
// been taken.
`default_nettype none

module time_segment_gap_tracker (
  input wire logic   clk,
  input wire logic   rst,
  tsgt_req_if.sink   req,
  tsgt_rsp_if.source rsp
);
  import tsgt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tsgt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tsgt_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .req_opcode (req.opcode),
    .req_start  (req.start_time),
    .req_stop   (req.stop_time),
    .req_gap    (req.gap_mark),
    .cmd        (cmd),
    .stat       (stat),
    .res_gap    (rsp.window_is_gap),
    .res_dur    (rsp.gap_duration),
    .res_status (rsp.status)
  );

  // One item in flight: never ready while a result is pending
  assert property (@(posedge clk) disable iff (rst) !(req.ready && rsp.valid))
    else $error("request ready while a result is pending");

  // At most one ring write per cycle
  assert property (@(posedge clk) disable iff (rst)
                   $onehot0({cmd.wr_merge, cmd.wr_replace, cmd.wr_add}))
    else $error("conflicting ring writes");

  // Ring is written only by appends
  assert property (@(posedge clk) disable iff (rst)
                   (cmd.wr_merge || cmd.wr_replace || cmd.wr_add) |-> !stat.is_query)
    else $error("ring write during a query");

  // Failed items carry no gap figures
  assert property (@(posedge clk) disable iff (rst)
                   (rsp.valid && (rsp.status != ST_OK))
                   |-> ((rsp.gap_duration == '0) && !rsp.window_is_gap))
    else $error("error result with gap figures");

  // A result appears only after a finish command
  assert property (@(posedge clk) disable iff (rst)
                   $rose(rsp.valid) |-> $past(cmd.finish))
    else $error("result without finish");

endmodule

`default_nettype wire
